// ===== hdl/preprocessor_token_lexer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the preprocessor token lexer
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PREPROCESSOR_TOKEN_LEXER_MACROS_SVH
`define PREPROCESSOR_TOKEN_LEXER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define PTL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");
`else
`define PTL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/ptl_pkg.sv =====
// ----------------------------------------------------------------------------
// Preprocessor token lexer package
// Character codes, token kinds and the types passed between the lexer parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptl_pkg;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [2:0] KIND_IDENT  = 3'd0;
    localparam logic [2:0] KIND_STRING = 3'd1;
    localparam logic [2:0] KIND_OTHER  = 3'd2;
    localparam logic [2:0] KIND_BAD    = 3'd3;
    localparam logic [2:0] KIND_EOF    = 3'd4;

    // One result transaction without its last flag.
    typedef struct packed {
        logic [7:0] out_char;
        logic       appended;
        logic       token_end;
        logic [2:0] token_kind;
    } res_t;

    // All results caused by one input byte; count is 1 to 3.
    typedef struct packed {
        logic [1:0]      count;
        res_t [2:0]      res;
    } bundle_t;

    // Front status seen by the top level.
    typedef struct packed {
        logic finished;
        logic push;
    } front_sts_t;

endpackage

// ===== hdl/ptl_ifs.sv =====
// ----------------------------------------------------------------------------
// Lexer channel interfaces
// Valid/ready channels for source bytes and for token results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_file;

    modport source (output valid, output ch, output end_of_file, input ready);
    modport sink   (input valid, input ch, input end_of_file, output ready);
endinterface

interface ptl_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       appended;
    logic       token_end;
    logic [2:0] token_kind;
    logic       last;

    modport source (output valid, output out_char, output appended, output token_end,
                    output token_kind, output last, input ready);
    modport sink   (input valid, input out_char, input appended, input token_end,
                    input token_kind, input last, output ready);
endinterface

// ===== hdl/ptl_front.sv =====
// ----------------------------------------------------------------------------
// Lexer front end
// Accepts source bytes, runs the lexing state machine and pushes the results
// of each byte as one bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    ptl_byte_if.sink             src,
    input  logic                 full,
    output logic                 push,
    output ptl_pkg::bundle_t     push_data,
    output ptl_pkg::front_sts_t  sts
);
    import ptl_pkg::*;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_SQUOTE  = 3'd2,
        MODE_DQUOTE  = 3'd3,
        MODE_COMMENT = 3'd4,
        MODE_OTHER   = 3'd5
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_char_reg, held_char_next;
    logic       held_valid_reg, held_valid_next;
    logic       swallow_next_reg, swallow_next_next;
    logic       swallow_nl_reg, swallow_nl_next;
    logic       escape_reg, escape_next;
    logic       finished_reg, finished_next;

    logic       accept;
    logic [7:0] c;
    logic [7:0] p;
    logic       peek_ok;
    logic       restart;
    logic [1:0] cnt;
    res_t [2:0] res;

    function automatic logic is_letter(input logic [7:0] x);
        return ((x >= 8'h41) && (x <= 8'h5A)) || ((x >= 8'h61) && (x <= 8'h7A));
    endfunction

    function automatic res_t mk(input logic [7:0] x, input logic app,
                                input logic fin, input logic [2:0] kind);
        res_t r;
        r.out_char   = app ? x : 8'h00;
        r.appended   = app;
        r.token_end  = fin;
        r.token_kind = fin ? kind : KIND_IDENT;
        return r;
    endfunction

    assign src.ready = !full;
    assign accept    = src.valid && src.ready;

    always_comb
    begin
        mode_next         = mode_reg;
        held_char_next    = held_char_reg;
        held_valid_next   = held_valid_reg;
        swallow_next_next = swallow_next_reg;
        swallow_nl_next   = swallow_nl_reg;
        escape_next       = escape_reg;
        finished_next     = finished_reg;
        c       = held_char_reg;
        p       = src.ch;
        peek_ok = !src.end_of_file;
        restart = 1'b0;
        cnt     = 2'd0;
        res     = '0;

        if (accept && !finished_reg)
        begin
            if (held_valid_reg)
            begin
                held_valid_next = 1'b0;
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (is_letter(c) || c == CH_DOT)
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                            cnt = cnt + 2'd1;
                        end
                        else
                        begin
                            res[cnt] = mk(c, 1'b0, 1'b1, KIND_IDENT);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_START;
                            restart = 1'b1;
                        end
                    end
                    MODE_SQUOTE:
                    begin
                        if (c == CH_SQUOTE)
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b1, KIND_STRING);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_START;
                        end
                        else if (c == CH_BSLASH && peek_ok && p == CH_SQUOTE)
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                            cnt = cnt + 2'd1;
                            escape_next = 1'b1;
                        end
                        else if (c == CH_NL)
                        begin
                            res[cnt] = mk(c, 1'b0, 1'b1, KIND_BAD);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_START;
                            swallow_next_next = 1'b1;
                        end
                        else
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                            cnt = cnt + 2'd1;
                        end
                    end
                    MODE_DQUOTE:
                    begin
                        if (c == CH_DQUOTE)
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b1, KIND_STRING);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_START;
                        end
                        else if (c == CH_BSLASH && peek_ok && p == CH_DQUOTE)
                        begin
                            swallow_next_next = 1'b1;
                        end
                        else if (c == CH_NL)
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b1, KIND_BAD);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_START;
                        end
                        else
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                            cnt = cnt + 2'd1;
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (c == CH_STAR && peek_ok && p == CH_SLASH)
                        begin
                            swallow_next_next = 1'b1;
                            swallow_nl_next   = 1'b1;
                            mode_next         = MODE_START;
                        end
                    end
                    MODE_OTHER:
                    begin
                        if (c == CH_SPACE || c == CH_NL)
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b1, KIND_OTHER);
                            cnt = cnt + 2'd1;
                            mode_next = MODE_START;
                        end
                        else if (c == CH_SLASH && peek_ok && p == CH_STAR)
                        begin
                            swallow_next_next = 1'b1;
                            mode_next = MODE_COMMENT;
                        end
                        else
                        begin
                            res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                            cnt = cnt + 2'd1;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_START;
                        restart = 1'b1;
                    end
                endcase

                // Start-mode judgment, also for the byte that ended an identifier.
                if (restart)
                begin
                    if (c == CH_SPACE || c == CH_TAB)
                    begin
                        mode_next = MODE_START;
                    end
                    else if (c == CH_HASH || is_letter(c))
                    begin
                        res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_IDENT;
                    end
                    else if (c == CH_SQUOTE)
                    begin
                        res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_SQUOTE;
                    end
                    else if (c == CH_DQUOTE)
                    begin
                        res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_DQUOTE;
                    end
                    else if (c == CH_SLASH && peek_ok && p == CH_STAR)
                    begin
                        swallow_next_next = 1'b1;
                        mode_next = MODE_COMMENT;
                    end
                    else if (c == CH_NL)
                    begin
                        res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                        cnt = cnt + 2'd1;
                    end
                    else
                    begin
                        res[cnt] = mk(c, 1'b1, 1'b0, KIND_IDENT);
                        cnt = cnt + 2'd1;
                        mode_next = MODE_OTHER;
                    end
                end
            end

            if (src.end_of_file)
            begin
                unique case (mode_next)
                    MODE_START: res[cnt] = mk(8'h00, 1'b0, 1'b1, KIND_EOF);
                    MODE_IDENT: res[cnt] = mk(8'h00, 1'b0, 1'b1, KIND_IDENT);
                    MODE_OTHER: res[cnt] = mk(8'h00, 1'b0, 1'b1, KIND_OTHER);
                    default:    res[cnt] = mk(8'h00, 1'b0, 1'b1, KIND_BAD);
                endcase
                cnt = cnt + 2'd1;
                mode_next         = MODE_START;
                swallow_next_next = 1'b0;
                swallow_nl_next   = 1'b0;
                escape_next       = 1'b0;
                held_char_next    = 8'h00;
                finished_next     = 1'b1;
            end
            else if (escape_next)
            begin
                escape_next = 1'b0;
                res[cnt] = mk(src.ch, 1'b1, 1'b0, KIND_IDENT);
                cnt = cnt + 2'd1;
            end
            else if (swallow_next_next)
            begin
                swallow_next_next = 1'b0;
            end
            else if (swallow_nl_next)
            begin
                swallow_nl_next = 1'b0;
                if (src.ch != CH_NL)
                begin
                    held_char_next  = src.ch;
                    held_valid_next = 1'b1;
                end
            end
            else
            begin
                held_char_next  = src.ch;
                held_valid_next = 1'b1;
            end
        end
    end

    assign push            = (cnt != 2'd0);
    assign push_data.count = cnt;
    assign push_data.res   = res;
    assign sts.finished    = finished_reg;
    assign sts.push        = push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_START;
            held_char_reg    <= 8'h00;
            held_valid_reg   <= 1'b0;
            swallow_next_reg <= 1'b0;
            swallow_nl_reg   <= 1'b0;
            escape_reg       <= 1'b0;
            finished_reg     <= 1'b0;
        end
        else
        begin
            mode_reg         <= mode_next;
            held_char_reg    <= held_char_next;
            held_valid_reg   <= held_valid_next;
            swallow_next_reg <= swallow_next_next;
            swallow_nl_reg   <= swallow_nl_next;
            escape_reg       <= escape_next;
            finished_reg     <= finished_next;
        end
    end

endmodule

// ===== hdl/ptl_fifo.sv =====
// ----------------------------------------------------------------------------
// Lexer bundle queue
// Two-entry queue of result bundles between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptl_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ptl_pkg::bundle_t  push_data,
    input  logic              pop,
    output ptl_pkg::bundle_t  pop_data,
    output logic              full,
    output logic              empty
);
    import ptl_pkg::*;

    bundle_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/ptl_back.sv =====
// ----------------------------------------------------------------------------
// Lexer back end
// Takes bundles from the queue and sends their results one per cycle while tok.ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  ptl_pkg::bundle_t  pop_data,
    output logic              pop,
    ptl_tok_if.source         tok
);
    import ptl_pkg::*;

    bundle_t    cur_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       is_last;
    logic       fire;
    res_t       sel;

    assign is_last = (idx_reg == (cur_reg.count - 2'd1));
    assign fire    = busy_reg && tok.ready;
    assign pop     = !empty && (!busy_reg || (fire && is_last));
    assign sel     = cur_reg.res[idx_reg];

    assign tok.valid      = busy_reg;
    assign tok.out_char   = sel.out_char;
    assign tok.appended   = sel.appended;
    assign tok.token_end  = sel.token_end;
    assign tok.token_kind = sel.token_kind;
    assign tok.last       = is_last;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule

// ===== hdl/preprocessor_token_lexer.sv =====
// ----------------------------------------------------------------------------
// Preprocessor token lexer
// Streaming lexer that turns source bytes into token text and token ends.
// ----------------------------------------------------------------------------
//  Channel   Dir   Payload                                          Handshake
//  src       in    ch[7:0], end_of_file                             valid/ready
//  tok       out   out_char[7:0], appended, token_end,              valid/ready
//                  token_kind[2:0], last
//
//  A byte is taken whenever the two-entry bundle queue has room.
//  Results leave one per cycle from the back end while tok is ready, and
//  a byte makes at most three results.
//  Reset is asynchronous and active low; no clearing pass follows it.
//  A stall on tok fills the queue and then drops src.ready; src stalls
//  leave the back end free to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "preprocessor_token_lexer_macros.svh"

module preprocessor_token_lexer (
    input  logic    clk,
    input  logic    rst_n,
    ptl_byte_if.sink  src,
    ptl_tok_if.source tok
);
    import ptl_pkg::*;

    // The front end judges each held byte against the next one and builds the
    // whole set of results for that transaction at once.
    logic       push;
    bundle_t    push_data;
    logic       full;
    logic       empty;
    logic       pop;
    bundle_t    pop_data;
    front_sts_t sts;

    ptl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src       (src),
        .full      (full),
        .push      (push),
        .push_data (push_data),
        .sts       (sts)
    );

    // The queue lets the front take bytes while the back end is still
    // sending an earlier bundle.
    ptl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    // The back end serializes each bundle and flags its final result.
    ptl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .tok      (tok)
    );

    // Once the end of file has been handled, no further results are made.
    `PTL_ASSERT_IMPLIES(a_quiet_after_eof, clk, rst_n, sts.push, !sts.finished)
    // An accepted end-of-file transaction always finishes the lexer.
    `PTL_ASSERT_NEXT(a_eof_finishes, clk, rst_n,
        src.valid && src.ready && src.end_of_file, sts.finished)
    // A result that carries no token text has a zero character.
    `PTL_ASSERT_IMPLIES(a_clean_char, clk, rst_n,
        tok.valid && !tok.appended, tok.out_char == 8'h00)

endmodule
